FILE: sv/seeg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seeg_pkg
// Shared codes and widths for the speech edge and echo gate core.
// ----------------------------------------------------------------------------
package seeg_pkg;

    // Item operation codes
    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_ARM   = 2'd1;
    localparam logic [1:0] OP_DISC  = 2'd2;

    // Playback end codes (any other code acts as a natural finish)
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_INTR = 2'd1;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_ADDR_W-1:0] CFG_START  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_END    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ADMIT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WARMUP = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TAIL   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_WARN   = 3'd5;

    // Reset values of the configuration registers
    localparam logic [5:0]         RST_START  = 6'd6;
    localparam logic [5:0]         RST_END    = 6'd35;
    localparam logic signed [11:0] RST_ADMIT  = -12'sd500;
    localparam logic [5:0]         RST_WARMUP = 6'd30;
    localparam logic [5:0]         RST_TAIL   = 6'd15;
    localparam logic [6:0]         RST_WARN   = 7'd50;

    // Wait counter ceiling
    localparam logic [6:0] WAIT_MAX = 7'd127;

    // Captured input item
    typedef struct packed {
        logic [1:0]         operation;
        logic               vad_voiced;
        logic signed [11:0] mic_level;
        logic               reference_present;
        logic [1:0]         playback_end;
        logic               render_active;
        logic               playback_audible;
    } item_t;

endpackage

FILE: sv/speech_edge_and_echo_gate_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speech_edge_and_echo_gate_core
// Per-frame voice admission, speech start/end debounce and playback echo gate.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  s_      | in        | s_valid / s_ready  | operation, verdict, level, gate
//  m_      | out       | m_valid / m_ready  | voice/edge/near/warn flags
//  cfg_    | in        | cfg_wr_en          | cfg_addr, cfg_wdata
//
// An item is held in the input register, then its state update and result
// are done in one pass into the result register. One item per cycle is
// sustained, but a stalled result holds a frame in the input register; arm
// and discontinuity items never wait on it. Reset (aresetn low, synchronous)
// restores the register defaults and clears all gate and debounce state.
module speech_edge_and_echo_gate_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic                          s_vad_voiced,
    input  logic signed [11:0]            s_mic_level,
    input  logic                          s_reference_present,
    input  logic [1:0]                    s_playback_end,
    input  logic                          s_render_active,
    input  logic                          s_playback_audible,
    // result items
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_voice_now,
    output logic                          m_speech_started,
    output logic                          m_speech_ended,
    output logic                          m_local_talk,
    output logic                          m_reference_missing,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [seeg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [seeg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import seeg_pkg::*;

    // Configuration registers
    logic [5:0]         start_frames_reg;
    logic [5:0]         end_frames_reg;
    logic signed [11:0] admission_level_reg;
    logic [5:0]         warmup_frames_reg;
    logic [5:0]         tail_frames_reg;
    logic [6:0]         warn_frames_reg;

    // Input register
    logic  in_valid_reg;
    item_t in_item_reg;

    // Block state
    logic [5:0] voiced_count_reg, voiced_count_next;
    logic [5:0] unvoiced_count_reg, unvoiced_count_next;
    logic       in_speech_reg, in_speech_next;
    logic       session_active_reg, session_active_next;
    logic       warmup_armed_reg, warmup_armed_next;
    logic       silent_bypass_reg, silent_bypass_next;
    logic [5:0] suppress_left_reg, suppress_left_next;
    logic [6:0] wait_count_reg, wait_count_next;

    // Result register
    logic m_valid_reg;
    logic voice_now_reg, speech_started_reg, speech_ended_reg;
    logic local_talk_reg, reference_missing_reg;

    // Per-frame intermediates
    logic       advance;
    logic       is_frame;
    logic       now, started, ended, suppress, warn;
    logic [6:0] vc_inc, uc_inc;
    logic [5:0] vc_new, uc_new;
    logic [5:0] sl_mid;
    logic [6:0] wait_inc;

    // Handshake: a frame needs a free result slot, other items pass at once
    assign is_frame = (in_item_reg.operation == OP_FRAME);
    assign advance  = in_valid_reg && (!is_frame || !m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_frames_reg    <= RST_START;
            end_frames_reg      <= RST_END;
            admission_level_reg <= RST_ADMIT;
            warmup_frames_reg   <= RST_WARMUP;
            tail_frames_reg     <= RST_TAIL;
            warn_frames_reg     <= RST_WARN;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_START:  start_frames_reg    <= cfg_wdata[5:0];
                CFG_END:    end_frames_reg      <= cfg_wdata[5:0];
                CFG_ADMIT:  admission_level_reg <= $signed(cfg_wdata[11:0]);
                CFG_WARMUP: warmup_frames_reg   <= cfg_wdata[5:0];
                CFG_TAIL:   tail_frames_reg     <= cfg_wdata[5:0];
                CFG_WARN:   warn_frames_reg     <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_item_reg.operation         <= s_operation;
            in_item_reg.vad_voiced        <= s_vad_voiced;
            in_item_reg.mic_level         <= s_mic_level;
            in_item_reg.reference_present <= s_reference_present;
            in_item_reg.playback_end      <= s_playback_end;
            in_item_reg.render_active     <= s_render_active;
            in_item_reg.playback_audible  <= s_playback_audible;
        end
    end

    // Admission and debounce, counters saturate at their threshold
    always_comb begin
        now    = in_item_reg.vad_voiced &&
                 (in_speech_reg || (in_item_reg.mic_level >= admission_level_reg));
        vc_inc = {1'b0, voiced_count_reg} + 7'd1;
        uc_inc = {1'b0, unvoiced_count_reg} + 7'd1;
        if (now) begin
            vc_new = (vc_inc < {1'b0, start_frames_reg}) ? vc_inc[5:0] : start_frames_reg;
            uc_new = 6'd0;
        end else begin
            vc_new = 6'd0;
            uc_new = (uc_inc < {1'b0, end_frames_reg}) ? uc_inc[5:0] : end_frames_reg;
        end
        started = !in_speech_reg && (vc_new >= start_frames_reg);
        ended   = in_speech_reg && !started && (uc_new >= end_frames_reg);
    end

    // Next state for all item kinds
    always_comb begin
        voiced_count_next   = voiced_count_reg;
        unvoiced_count_next = unvoiced_count_reg;
        in_speech_next      = in_speech_reg;
        session_active_next = session_active_reg;
        warmup_armed_next   = warmup_armed_reg;
        silent_bypass_next  = silent_bypass_reg;
        suppress_left_next  = suppress_left_reg;
        wait_count_next     = wait_count_reg;
        sl_mid              = suppress_left_reg;
        wait_inc            = wait_count_reg + 7'd1;
        suppress            = 1'b0;
        warn                = 1'b0;

        case (in_item_reg.operation)
            OP_ARM: begin
                session_active_next = 1'b1;
                warmup_armed_next   = 1'b1;
                silent_bypass_next  = 1'b0;
                suppress_left_next  = 6'd0;
                wait_count_next     = 7'd0;
            end
            OP_DISC: begin
                // no effect outside a session
                if (session_active_reg) begin
                    warmup_armed_next  = 1'b1;
                    suppress_left_next = 6'd0;
                end
            end
            OP_FRAME: begin
                voiced_count_next   = vc_new;
                unvoiced_count_next = uc_new;
                if (started) begin
                    in_speech_next = 1'b1;
                end else if (ended) begin
                    in_speech_next = 1'b0;
                end

                // playback gate
                if (in_item_reg.playback_end != PEND_NONE) begin
                    session_active_next = 1'b0;
                    warmup_armed_next   = 1'b0;
                    silent_bypass_next  = 1'b0;
                    if (in_item_reg.playback_end == PEND_INTR) begin
                        sl_mid = 6'd0;
                    end else begin
                        sl_mid   = tail_frames_reg;
                        suppress = 1'b1;
                    end
                end else if (silent_bypass_reg && in_item_reg.playback_audible) begin
                    silent_bypass_next = 1'b0;
                    warmup_armed_next  = 1'b1;
                    wait_count_next    = 7'd0;
                    suppress           = 1'b1;
                end else if (warmup_armed_reg) begin
                    suppress = 1'b1;
                    if (!in_item_reg.render_active) begin
                        wait_count_next = 7'd0;
                    end else if (!in_item_reg.playback_audible) begin
                        warmup_armed_next  = 1'b0;
                        silent_bypass_next = 1'b1;
                        wait_count_next    = 7'd0;
                        suppress           = 1'b0;
                    end else if (in_item_reg.reference_present) begin
                        warmup_armed_next = 1'b0;
                        sl_mid            = warmup_frames_reg;
                        wait_count_next   = 7'd0;
                    end else if (wait_count_reg < WAIT_MAX) begin
                        wait_count_next = wait_inc;
                        warn            = (wait_inc == warn_frames_reg);
                    end
                end

                // suppression countdown; expiry clears the debounce state
                suppress_left_next = sl_mid;
                if (sl_mid != 6'd0) begin
                    suppress           = 1'b1;
                    suppress_left_next = sl_mid - 6'd1;
                    if (sl_mid == 6'd1) begin
                        voiced_count_next   = 6'd0;
                        unvoiced_count_next = 6'd0;
                        in_speech_next      = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voiced_count_reg   <= 6'd0;
            unvoiced_count_reg <= 6'd0;
            in_speech_reg      <= 1'b0;
            session_active_reg <= 1'b0;
            warmup_armed_reg   <= 1'b0;
            silent_bypass_reg  <= 1'b0;
            suppress_left_reg  <= 6'd0;
            wait_count_reg     <= 7'd0;
        end else if (advance) begin
            voiced_count_reg   <= voiced_count_next;
            unvoiced_count_reg <= unvoiced_count_next;
            in_speech_reg      <= in_speech_next;
            session_active_reg <= session_active_next;
            warmup_armed_reg   <= warmup_armed_next;
            silent_bypass_reg  <= silent_bypass_next;
            suppress_left_reg  <= suppress_left_next;
            wait_count_reg     <= wait_count_next;
        end
    end

    // Result register, loaded by frames only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && is_frame) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && is_frame) begin
            voice_now_reg         <= now;
            speech_started_reg    <= started;
            speech_ended_reg      <= ended;
            local_talk_reg        <= now && !suppress;
            reference_missing_reg <= warn;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_voice_now         = voice_now_reg;
    assign m_speech_started    = speech_started_reg;
    assign m_speech_ended      = speech_ended_reg;
    assign m_local_talk        = local_talk_reg;
    assign m_reference_missing = reference_missing_reg;

    // Checks
    a_no_result_from_events: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !is_frame && !m_valid_reg) |=> !m_valid_reg)
        else $error("result produced by a non-frame item");

    a_single_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(speech_started_reg && speech_ended_reg))
        else $error("speech start and end on the same frame");

    a_near_implies_voice: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && local_talk_reg) |-> voice_now_reg)
        else $error("near voice without admitted voice");

    a_frame_waits_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && is_frame && m_valid_reg && !m_ready) |=> in_valid_reg)
        else $error("frame item dropped while result stalled");

endmodule
